FILE: rtl/core/kmct_pkg.sv
// ----------------------------------------------------------------------------
// kmct_pkg
// Shared types and constants of the keyed mark correlation table.
// ----------------------------------------------------------------------------
`default_nettype none
package kmct_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] FUNC_MARK  = 2'd0;
    localparam logic [1:0] FUNC_TOUCH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam logic [0:0] REG_WINDOW   = 1'b0;
    localparam logic [0:0] REG_COOLDOWN = 1'b1;

    localparam logic [26:0] WINDOW_RST   = 27'd10000;
    localparam logic [26:0] COOLDOWN_RST = 27'd3000;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_MEDIUM = 2'd1;
    localparam logic [1:0] KIND_STRONG = 2'd2;
    localparam logic [1:0] KIND_TXF    = 2'd3;

    // One slot of the table
    typedef struct packed {
        logic [31:0] actor;
        logic [31:0] target;
        logic [9:0]  marks;
        logic [63:0] first_seen;
        logic [63:0] last_seen;
        logic [63:0] last_strong;
        logic [63:0] last_medium;
    } t_slot;

    // Severity for an alert kind
    function automatic logic [3:0] sev_of(input logic [1:0] kind);
        logic [3:0] s;
        case (kind)
            KIND_MEDIUM: s = 4'd5;
            KIND_STRONG: s = 4'd7;
            KIND_TXF:    s = 4'd8;
            default:     s = 4'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/keyed_mark_correlation_table_core.sv
// ----------------------------------------------------------------------------
// keyed_mark_correlation_table_core
// Keyed (actor, target) table with mark correlation and cooldown alerts.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | i_valid / o_ready     | i_func i_actor_id i_target_id i_mark_bits i_now_tick
//  out     | o_valid / i_ready     | o_alert_kind o_severity o_alert_actor o_alert_target
//          |                       | o_alert_marks o_slot_used
//  cfg     | i_cfg_we              | i_cfg_idx i_cfg_data
//
// A lookup reads one slot per cycle from the slot memory, in index order, and
// stops at a free, matching or stale slot; if none is found, the least recently
// seen slot is reused once the last one is tested. The scan is followed by a
// read of the chosen slot, an evaluate step and a write-back that loads the
// result; the block then returns to idle to take the next request. Clear and
// no-op requests go straight to the output step. Reset empties the table at once
// through per-slot valid bits. A result not yet taken holds only the write-back
// or output step; the next request is accepted and scanned meanwhile.
`default_nettype none
module keyed_mark_correlation_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_actor_id,
    input  wire logic [31:0] i_target_id,
    input  wire logic [9:0]  i_mark_bits,
    input  wire logic [63:0] i_now_tick,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_alert_kind,
    output logic [3:0]       o_severity,
    output logic [31:0]      o_alert_actor,
    output logic [31:0]      o_alert_target,
    output logic [9:0]       o_alert_marks,
    output logic [5:0]       o_slot_used,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [26:0] i_cfg_data
);
    localparam int IW = kmct_pkg::IDX_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_READ  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [26:0] r_window, r_cooldown;
    logic [kmct_pkg::ENTRIES-1:0] r_valid;
    kmct_pkg::t_slot r_mem [kmct_pkg::ENTRIES];
    kmct_pkg::t_slot r_rd;
    logic [IW-1:0] r_rd_addr;

    logic [1:0]  r_func;
    logic [31:0] r_actor, r_target;
    logic [9:0]  r_bits;
    logic [63:0] r_now;
    logic [kmct_pkg::CNT_W-1:0] r_idx;
    logic        r_rd_ok;
    logic [IW-1:0] r_pick;
    logic        r_have;
    logic [63:0] r_oldest;
    logic        r_fresh;

    kmct_pkg::t_slot w_base, w_eval;
    logic [1:0]  w_kind;

    logic        r_oval;
    logic [1:0]  r_kind;
    logic [31:0] r_oact, r_otgt;
    logic [9:0]  r_omarks;
    logic [5:0]  r_oslot;

    logic [IW-1:0] w_raddr;
    logic          w_rd_valid;
    logic          w_out_free;
    logic          w_load;
    logic          accept;

    assign accept     = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_rd_valid = r_valid[r_rd_addr];
    assign w_out_free = !r_oval || i_ready;
    assign w_load     = w_out_free && (r_state == S_WRITE || r_state == S_OUT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= kmct_pkg::WINDOW_RST;
            r_cooldown <= kmct_pkg::COOLDOWN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == kmct_pkg::REG_WINDOW) r_window <= i_cfg_data;
            else                                   r_cooldown <= i_cfg_data;
        end
    end

    // Read address: scan index, or chosen slot
    always_comb begin
        if (r_state == S_SCAN) w_raddr = r_idx[IW-1:0];
        else                   w_raddr = r_pick;
    end

    // Slot memory with registered read
    always_ff @(posedge i_clk) begin
        r_rd      <= r_mem[w_raddr];
        r_rd_addr <= w_raddr;
        if (r_state == S_WRITE && w_out_free) r_mem[r_pick] <= w_eval;
    end

    // Base slot fed to the evaluator: fresh or stored
    always_comb begin
        w_base = r_rd;
        if (r_fresh) begin
            w_base.actor       = r_actor;
            w_base.target      = r_target;
            w_base.marks       = 10'd0;
            w_base.first_seen  = r_now;
            w_base.last_seen   = r_now;
            w_base.last_strong = 64'd0;
            w_base.last_medium = 64'd0;
        end
    end

    kmct_eval u_eval (
        .i_clk      (i_clk),
        .i_mark     (r_func == kmct_pkg::FUNC_MARK),
        .i_slot     (w_base),
        .i_bits     (r_bits),
        .i_now      (r_now),
        .i_window   (r_window),
        .i_cooldown (r_cooldown),
        .o_slot     (w_eval),
        .o_kind     (w_kind)
    );

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_load) begin
            r_oval <= 1'b1;
        end else if (i_ready) begin
            r_oval <= 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func   <= i_func;
                        r_target <= i_target_id;
                        r_actor  <= (i_actor_id == 32'd0) ? i_target_id : i_actor_id;
                        r_bits   <= i_mark_bits;
                        r_now    <= i_now_tick;
                        r_idx    <= '0;
                        r_rd_ok  <= 1'b0;
                        r_have   <= 1'b0;
                        r_fresh  <= 1'b0;
                        r_pick   <= '0;
                        if (i_func == kmct_pkg::FUNC_CLEAR ||
                            i_func == kmct_pkg::FUNC_SPARE ||
                            i_target_id == 32'd0 ||
                            (i_func == kmct_pkg::FUNC_MARK && i_mark_bits == 10'd0)) begin
                            if (i_func == kmct_pkg::FUNC_CLEAR) r_valid <= '0;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue next read, test the previous one
                    if (r_idx != kmct_pkg::CNT_W'(kmct_pkg::ENTRIES)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_rd_ok <= 1'b1;
                    if (r_rd_ok) begin
                        if (!w_rd_valid) begin
                            r_pick <= r_rd_addr; r_fresh <= 1'b1; r_state <= S_READ;
                        end else if (r_rd.target == r_target && r_rd.actor == r_actor) begin
                            r_pick <= r_rd_addr; r_state <= S_READ;
                        end else if ((r_now - r_rd.last_seen) > {36'd0, r_window, 1'b0}) begin
                            r_pick <= r_rd_addr; r_fresh <= 1'b1; r_state <= S_READ;
                        end else begin
                            if (!r_have || r_rd.last_seen < r_oldest) begin
                                r_have   <= 1'b1;
                                r_oldest <= r_rd.last_seen;
                                r_pick   <= r_rd_addr;
                            end
                            if (r_rd_addr == IW'(kmct_pkg::ENTRIES - 1)) begin
                                r_fresh <= 1'b1;
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: r_state <= S_WRITE;
                S_WRITE: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_valid[r_pick] <= 1'b1;
                        r_kind   <= w_kind;
                        r_oact   <= w_eval.actor;
                        r_otgt   <= w_eval.target;
                        r_omarks <= w_eval.marks;
                        r_oslot  <= 6'(r_pick);
                        r_state  <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_kind   <= kmct_pkg::KIND_NONE;
                        r_oact   <= '0;
                        r_otgt   <= '0;
                        r_omarks <= '0;
                        r_oslot  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_oval;
    assign o_alert_kind   = r_kind;
    assign o_severity     = kmct_pkg::sev_of(r_kind);
    assign o_alert_actor  = r_oact;
    assign o_alert_target = r_otgt;
    assign o_alert_marks  = r_omarks;
    assign o_slot_used    = r_oslot;
endmodule
`default_nettype wire

FILE: rtl/core/kmct_eval.sv
// ----------------------------------------------------------------------------
// kmct_eval
// Mark update and chain-rule evaluation of one slot (registered result).
// ----------------------------------------------------------------------------
`default_nettype none
module kmct_eval (
    input  wire logic           i_clk,
    input  wire logic           i_mark,
    input  wire kmct_pkg::t_slot i_slot,
    input  wire logic [9:0]     i_bits,
    input  wire logic [63:0]    i_now,
    input  wire logic [26:0]    i_window,
    input  wire logic [26:0]    i_cooldown,
    output kmct_pkg::t_slot     o_slot,
    output logic [1:0]          o_kind
);
    kmct_pkg::t_slot n_slot;
    logic [1:0]      n_kind;
    logic [9:0]      m;
    logic [63:0]     fs;
    logic            th, is_strong, is_medium;

    // Merge marks, test window, then rules under cooldown
    always_comb begin
        n_slot = i_slot;
        n_kind = kmct_pkg::KIND_NONE;
        n_slot.last_seen = i_now;
        m  = i_slot.marks;
        fs = i_slot.first_seen;
        th = 1'b0; is_strong = 1'b0; is_medium = 1'b0;
        if (i_mark) begin
            m  = i_slot.marks | i_bits;
            if (fs == 64'd0) fs = i_now;
            th = m[4] | m[5];
            is_strong = m[0] & m[1] & m[2] & m[3] & th & (m[6] | m[8]);
            is_medium = (m[1] & m[2] & m[3] & th) | (m[0] & th & m[6]);
            n_slot.marks = m;
            n_slot.first_seen = fs;
            if ((i_now - fs) > {37'd0, i_window}) begin
                n_slot.marks = 10'd0;
                n_slot.first_seen = i_now;
            end else if (is_strong &&
                         (i_now - i_slot.last_strong) > {37'd0, i_cooldown}) begin
                n_slot.last_strong = i_now;
                n_kind = m[9] ? kmct_pkg::KIND_TXF : kmct_pkg::KIND_STRONG;
            end else if (is_medium &&
                         (i_now - i_slot.last_medium) > {37'd0, i_cooldown}) begin
                n_slot.last_medium = i_now;
                n_kind = kmct_pkg::KIND_MEDIUM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_slot <= n_slot;
        o_kind <= n_kind;
    end
endmodule
`default_nettype wire
